FILE: rtl/core/otmr_pkg.sv
package otmr_pkg;

  localparam int SLOTS_DEFAULT = 16;

  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_STOP   = 2'd1;
  localparam logic [1:0] MODE_ELAPSE = 2'd2;
  localparam logic [1:0] MODE_REPORT = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] timer_id;
    logic [31:0] amount;
  } cmd_word_t;

  typedef struct packed {
    logic [15:0] report_id;
    logic [31:0] remaining;
    logic        none_running;
    logic        last;
  } rsp_word_t;

  // one table slot as held in the slot memory
  typedef struct packed {
    logic [15:0] ident;
    logic [31:0] tm;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TEST
  } state_t;

endpackage

FILE: rtl/core/otmr_ram.sv
module otmr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/ordered_timer_table.sv
// Ordered timer table: up to SLOTS timers (id, remaining ms) kept in start order.
// Command channel: cmd_valid / cmd_stall / cmd (mode, timer_id, amount).
//   start places a timer last (a running id moves, not duplicated; amount zero
//   only stops it; a full table drops it), stop removes an id, elapse subtracts
//   from every timer, freeing those that reach zero; report lists running ones.
// Result channel: rsp_valid / rsp_stall / rsp, driven only by report commands.
//   One word per running timer in start order, last set on the final one; an
//   empty table gives a single word with none_running and last set.
// Every command walks the occupied slots through one slot memory with a
// registered read and one shared subtract/compare unit: ST_SCAN reads a slot,
// ST_TEST acts on it, and a last ST_SCAN with idx == used ends the walk,
// where start appends its timer. cmd_stall is high for the whole walk.
// The result word sits in an output register, so a new command is taken while
// the last word still waits; a stalled receiver holds a report walk in place.
// Reset empties the table by clearing the slot count; there is no clearing
// pass, and the block takes a command straight out of reset.
module ordered_timer_table #(
  parameter int SLOTS = otmr_pkg::SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  otmr_pkg::cmd_word_t cmd,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output otmr_pkg::rsp_word_t rsp
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = $bits(otmr_pkg::entry_t);

  otmr_pkg::state_t    state, state_next;
  otmr_pkg::cmd_word_t cmd_reg;
  logic [CW-1:0]       used, used_next;
  logic [CW-1:0]       idx, idx_next;
  logic [CW-1:0]       keep, keep_next;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  otmr_pkg::entry_t    ram_wdata, ram_rdata;

  logic                rsp_load;
  otmr_pkg::rsp_word_t rsp_next;
  logic                rsp_free;

  logic [32:0]         diff;
  logic                alive;

  otmr_ram #(
    .WIDTH(EW),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // shared unit: remaining time minus elapsed amount, with borrow
  assign diff  = {1'b0, ram_rdata.tm} - {1'b0, cmd_reg.amount};
  assign alive = !diff[32] && (diff[31:0] != 32'd0);

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign cmd_stall = (state != otmr_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= otmr_pkg::ST_IDLE;
      used  <= '0;
      idx   <= '0;
      keep  <= '0;
    end else begin
      state <= state_next;
      used  <= used_next;
      idx   <= idx_next;
      keep  <= keep_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == otmr_pkg::ST_IDLE && cmd_valid) begin
      cmd_reg <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  always_comb begin
    state_next = state;
    used_next  = used;
    idx_next   = idx;
    keep_next  = keep;
    ram_we     = 1'b0;
    ram_waddr  = keep[AW-1:0];
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = idx[AW-1:0];
    rsp_load   = 1'b0;
    rsp_next   = '0;
    case (state)
      otmr_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          state_next = otmr_pkg::ST_SCAN;
          idx_next   = '0;
          keep_next  = '0;
        end
      end
      otmr_pkg::ST_SCAN: begin
        if (idx == used) begin
          if (cmd_reg.mode == otmr_pkg::MODE_REPORT) begin
            if (used == '0) begin
              if (rsp_free) begin
                rsp_load              = 1'b1;
                rsp_next.none_running = 1'b1;
                rsp_next.last         = 1'b1;
                state_next            = otmr_pkg::ST_IDLE;
              end
            end else begin
              state_next = otmr_pkg::ST_IDLE;
            end
          end else begin
            // append a started timer behind the survivors
            if (cmd_reg.mode == otmr_pkg::MODE_START && cmd_reg.amount != 32'd0 &&
                keep < CW'(SLOTS)) begin
              ram_we          = 1'b1;
              ram_wdata.ident = cmd_reg.timer_id;
              ram_wdata.tm    = cmd_reg.amount;
              used_next       = keep + CW'(1);
            end else begin
              used_next = keep;
            end
            state_next = otmr_pkg::ST_IDLE;
          end
        end else begin
          ram_re     = 1'b1;
          state_next = otmr_pkg::ST_TEST;
        end
      end
      otmr_pkg::ST_TEST: begin
        case (cmd_reg.mode)
          otmr_pkg::MODE_REPORT: begin
            if (rsp_free) begin
              rsp_load           = 1'b1;
              rsp_next.report_id = ram_rdata.ident;
              rsp_next.remaining = ram_rdata.tm;
              rsp_next.last      = ((idx + CW'(1)) == used);
              idx_next           = idx + CW'(1);
              state_next         = otmr_pkg::ST_SCAN;
            end
          end
          otmr_pkg::MODE_ELAPSE: begin
            if (alive) begin
              ram_we       = 1'b1;
              ram_wdata.tm = diff[31:0];
              keep_next    = keep + CW'(1);
            end
            idx_next   = idx + CW'(1);
            state_next = otmr_pkg::ST_SCAN;
          end
          default: begin
            // start and stop: drop the entry with the commanded id, compact the rest
            if (ram_rdata.ident != cmd_reg.timer_id) begin
              ram_we    = 1'b1;
              keep_next = keep + CW'(1);
            end
            idx_next   = idx + CW'(1);
            state_next = otmr_pkg::ST_SCAN;
          end
        endcase
      end
      default: begin
        state_next = otmr_pkg::ST_IDLE;
      end
    endcase
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(SLOTS))
    else $error("slot count exceeds table size");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    (state != otmr_pkg::ST_IDLE) |-> (keep <= idx && idx <= used))
    else $error("compaction write index ran ahead of read index");

  a_none_word: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.none_running) |->
      (rsp.last && rsp.report_id == 16'd0 && rsp.remaining == 32'd0))
    else $error("empty-table report word malformed");

  a_report_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (state != otmr_pkg::ST_IDLE && cmd_reg.mode == otmr_pkg::MODE_REPORT) |=>
      (used == $past(used)))
    else $error("report changed the slot count");

endmodule

FILE: tb/ordered_timer_table_checker.sv
`timescale 1ns / 1ps

module ordered_timer_table_checker #(
  parameter int SLOTS = otmr_pkg::SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  logic                cmd_stall,
  input  otmr_pkg::cmd_word_t cmd,
  input  logic                rsp_valid,
  input  logic                rsp_stall,
  input  otmr_pkg::rsp_word_t rsp,
  output int                  fail_count,
  output int                  words_pending,
  output int                  cmd_count,
  output int                  word_count,
  output int                  drop_count
);

  localparam int EXP_DEPTH = 1024;

  logic [15:0]         timer_ids [SLOTS];
  logic [31:0]         timer_ms  [SLOTS];
  int                  timers_used;
  otmr_pkg::rsp_word_t exp_words [EXP_DEPTH];
  int                  exp_wr;
  int                  exp_rd;

  task automatic queue_word(input otmr_pkg::rsp_word_t w);
    exp_words[exp_wr % EXP_DEPTH] = w;
    exp_wr++;
  endtask

  task automatic remove_timer(input logic [15:0] id);
    int pos;
    int i;
    pos = -1;
    for (i = 0; i < timers_used; i++) begin
      if (pos < 0 && timer_ids[i] == id) pos = i;
    end
    if (pos >= 0) begin
      for (i = pos; i < timers_used - 1; i++) begin
        timer_ids[i] = timer_ids[i + 1];
        timer_ms[i]  = timer_ms[i + 1];
      end
      timers_used--;
    end
  endtask

  task automatic apply_timer_cmd(input otmr_pkg::cmd_word_t w);
    otmr_pkg::rsp_word_t word;
    int keep;
    int i;
    case (w.mode)
      otmr_pkg::MODE_START: begin
        remove_timer(w.timer_id);
        // zero duration expires at once; a full table drops the start
        if (w.amount != '0) begin
          if (timers_used < SLOTS) begin
            timer_ids[timers_used] = w.timer_id;
            timer_ms[timers_used]  = w.amount;
            timers_used++;
          end else begin
            drop_count++;
          end
        end
      end
      otmr_pkg::MODE_STOP: remove_timer(w.timer_id);
      otmr_pkg::MODE_ELAPSE: begin
        keep = 0;
        for (i = 0; i < timers_used; i++) begin
          if (timer_ms[i] > w.amount) begin
            timer_ids[keep] = timer_ids[i];
            timer_ms[keep]  = timer_ms[i] - w.amount;
            keep++;
          end
        end
        timers_used = keep;
      end
      otmr_pkg::MODE_REPORT: begin
        if (timers_used == 0) begin
          word.report_id    = '0;
          word.remaining    = '0;
          word.none_running = 1'b1;
          word.last         = 1'b1;
          queue_word(word);
        end else begin
          for (i = 0; i < timers_used; i++) begin
            word.report_id    = timer_ids[i];
            word.remaining    = timer_ms[i];
            word.none_running = 1'b0;
            word.last         = (i == timers_used - 1);
            queue_word(word);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_word(input otmr_pkg::rsp_word_t got);
    otmr_pkg::rsp_word_t want;
    word_count++;
    if (exp_wr == exp_rd) begin
      fail_count++;
      if (fail_count <= 10)
        $display("ERROR: unexpected report word id %h ms %h none %b last %b",
                 got.report_id, got.remaining, got.none_running, got.last);
    end else begin
      want = exp_words[exp_rd % EXP_DEPTH];
      exp_rd++;
      if (got.report_id !== want.report_id || got.remaining !== want.remaining ||
          got.none_running !== want.none_running || got.last !== want.last) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"ERROR: word %0d expected id %h ms %h none %b last %b,",
                    " got id %h ms %h none %b last %b"},
                   word_count, want.report_id, want.remaining, want.none_running,
                   want.last, got.report_id, got.remaining, got.none_running,
                   got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      timers_used = 0;
      exp_wr      = 0;
      exp_rd      = 0;
      fail_count  = 0;
      cmd_count   = 0;
      word_count  = 0;
      drop_count  = 0;
    end else begin
      // take the command first so a same-edge word still finds its expectation
      if (cmd_valid && !cmd_stall) begin
        apply_timer_cmd(cmd);
        cmd_count++;
      end
      if (rsp_valid && !rsp_stall) check_word(rsp);
    end
    words_pending = exp_wr - exp_rd;
  end

endmodule

FILE: tb/ordered_timer_table_tb.sv
`timescale 1ns / 1ps

module ordered_timer_table_tb;

  localparam int SLOTS        = otmr_pkg::SLOTS_DEFAULT;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
  localparam int PHASE_ITEMS  = 42;

  logic                clk;
  logic                rst;
  logic                cmd_valid;
  logic                cmd_stall;
  otmr_pkg::cmd_word_t cmd;
  logic                rsp_valid;
  logic                rsp_stall;
  otmr_pkg::rsp_word_t rsp;

  int fail_count;
  int words_pending;
  int cmd_count;
  int word_count;
  int drop_count;

  int idle_pct;
  int stall_pct;
  bit hold_req;

  logic [15:0] id_pool [8] = '{16'h0000, 16'h0001, 16'h00ff, 16'h7fff,
                               16'h8000, 16'hfffe, 16'hffff, 16'h1234};

  ordered_timer_table #(.SLOTS(SLOTS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  ordered_timer_table_checker #(.SLOTS(SLOTS)) u_chk (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_stall     (cmd_stall),
    .cmd           (cmd),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp           (rsp),
    .fail_count    (fail_count),
    .words_pending (words_pending),
    .cmd_count     (cmd_count),
    .word_count    (word_count),
    .drop_count    (drop_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // receiver: random stall, or one long hold-off when asked
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // enter and leave at a falling edge; valid stays high between back-to-back words
  task automatic send_cmd(input logic [1:0] mode, input logic [15:0] id,
                          input logic [31:0] amt);
    otmr_pkg::cmd_word_t w;
    w.mode     = mode;
    w.timer_id = id;
    w.amount   = amt;
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd       <= w;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (words_pending != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_amount(input logic [1:0] mode);
    int sel;
    sel = $urandom_range(19);
    if (sel < 2) return '0;
    if (sel == 2) return 32'hffff_ffff;
    if (sel < 5) return $urandom;
    if (mode == otmr_pkg::MODE_ELAPSE) return 32'($urandom_range(1, 300));
    return 32'($urandom_range(1, 1000));
  endfunction

  function automatic otmr_pkg::cmd_word_t random_cmd();
    otmr_pkg::cmd_word_t w;
    int pick;
    pick = $urandom_range(99);
    w.timer_id = ($urandom_range(99) < 70) ? id_pool[$urandom_range(7)] : 16'($urandom);
    if (pick < 8) begin
      w.mode   = 2'($urandom);
      w.amount = $urandom;
      return w;
    end
    if (pick < 45)      w.mode = otmr_pkg::MODE_START;
    else if (pick < 60) w.mode = otmr_pkg::MODE_STOP;
    else if (pick < 78) w.mode = otmr_pkg::MODE_ELAPSE;
    else                w.mode = otmr_pkg::MODE_REPORT;
    w.amount = pick_amount(w.mode);
    return w;
  endfunction

  // overfill the table so the trailing starts are dropped, then list it
  task automatic fill_table();
    logic [15:0] base;
    int k;
    base = 16'($urandom);
    for (k = 0; k < SLOTS + 2; k++)
      send_cmd(otmr_pkg::MODE_START, base + 16'(k), 32'($urandom_range(1, 5000)));
    send_cmd(otmr_pkg::MODE_REPORT, '0, '0);
  endtask

  task automatic run_phase(input int sender_idle, input int recv_stall, input bit with_fill);
    otmr_pkg::cmd_word_t w;
    int n;
    idle_pct  = sender_idle;
    stall_pct = recv_stall;
    n = 0;
    if (with_fill) begin
      fill_table();
      n = SLOTS + 3;
    end
    for (; n < PHASE_ITEMS; n++) begin
      w = random_cmd();
      send_cmd(w.mode, w.timer_id, w.amount);
    end
  endtask

  initial begin
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed corners
    send_cmd(otmr_pkg::MODE_REPORT, '0, '0);
    send_cmd(otmr_pkg::MODE_START, 16'h0000, 32'h0000_0001);
    send_cmd(otmr_pkg::MODE_START, 16'hffff, 32'hffff_ffff);
    send_cmd(otmr_pkg::MODE_START, 16'h1234, '0);
    send_cmd(otmr_pkg::MODE_REPORT, '0, '0);
    send_cmd(otmr_pkg::MODE_START, 16'h0000, 32'd5);
    send_cmd(otmr_pkg::MODE_START, 16'hffff, '0);
    send_cmd(otmr_pkg::MODE_REPORT, '0, '0);
    send_cmd(otmr_pkg::MODE_STOP, 16'h5555, '0);
    send_cmd(otmr_pkg::MODE_STOP, 16'h0000, '0);
    send_cmd(otmr_pkg::MODE_REPORT, '0, '0);
    send_cmd(otmr_pkg::MODE_START, 16'h0007, 32'd10);
    send_cmd(otmr_pkg::MODE_START, 16'h0008, 32'd3);
    send_cmd(otmr_pkg::MODE_ELAPSE, '0, '0);
    send_cmd(otmr_pkg::MODE_REPORT, '0, '0);
    send_cmd(otmr_pkg::MODE_ELAPSE, 16'hffff, 32'd3);
    send_cmd(otmr_pkg::MODE_REPORT, '0, '0);
    send_cmd(otmr_pkg::MODE_ELAPSE, '0, 32'hffff_ffff);
    send_cmd(otmr_pkg::MODE_REPORT, '0, '0);

    run_phase(0, 0, 1'b1);
    cmd_valid <= 1'b0;
    wait_drained();

    // long receiver hold-off while commands keep coming, to back the block up
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b1;
    send_cmd(otmr_pkg::MODE_REPORT, '0, '0);
    repeat (4) begin
      send_cmd(otmr_pkg::MODE_START, 16'($urandom), 32'($urandom_range(1, 5000)));
      send_cmd(otmr_pkg::MODE_REPORT, '0, '0);
    end
    send_cmd(otmr_pkg::MODE_ELAPSE, '0, 32'd100);
    send_cmd(otmr_pkg::MODE_REPORT, '0, '0);
    cmd_valid <= 1'b0;
    wait_drained();

    run_phase(69, 0, 1'b0);
    cmd_valid <= 1'b0;
    wait_drained();
    run_phase(0, 69, 1'b1);
    cmd_valid <= 1'b0;
    wait_drained();
    run_phase(31, 31, 1'b0);
    cmd_valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display({"Ran %0d commands (start, stop, elapse, report) under four",
              " idle/stall mixes and a long hold-off;"}, cmd_count);
    $display("checked %0d report words, %0d starts dropped on a full table, %0d failures.",
             word_count, drop_count, fail_count);
    if (fail_count == 0 && words_pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/otmr_pkg.sv
rtl/core/otmr_ram.sv
rtl/core/ordered_timer_table.sv
tb/ordered_timer_table_checker.sv
tb/ordered_timer_table_tb.sv
